// ===== src/tqfl_pkg.sv =====
// Shared types and codes for the two-queue feedback lottery scheduler.
// No dependencies; used by the queue, the top level and the checker.
`default_nettype none
package tqfl_pkg;

    // Register indexes on the configuration port (word address).
    localparam logic [1:0] REG_QUANTUM    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_FAST_SHARE = 2'd2;

    localparam logic [15:0] QUANTUM_RESET    = 16'd100;
    localparam logic [6:0]  THRESHOLD_RESET  = 7'd50;
    localparam logic [6:0]  FAST_SHARE_RESET = 7'd70;

    // Exit state of a returning process.
    localparam logic [1:0] EXIT_READY    = 2'd0;
    localparam logic [1:0] EXIT_BLOCKED  = 2'd1;
    localparam logic [1:0] EXIT_FINISHED = 2'd2;

    // Where the returning process went.
    localparam logic [2:0] DEST_NONE     = 3'd0;
    localparam logic [2:0] DEST_FAST     = 3'd1;
    localparam logic [2:0] DEST_SLOW     = 3'd2;
    localparam logic [2:0] DEST_BLOCKED  = 3'd3;
    localparam logic [2:0] DEST_FINISHED = 3'd4;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_BAD_EXIT   = 2'd1;
    localparam logic [1:0] ERR_QUEUE_FULL = 2'd2;
    localparam logic [1:0] ERR_UNUSED     = 2'd3;

    localparam logic CLASS_FAST = 1'b0;
    localparam logic CLASS_SLOW = 1'b1;

    localparam logic QUEUE_FAST = 1'b0;
    localparam logic QUEUE_SLOW = 1'b1;

    // Usage product width: 65535 * 100 and 127 * 65535 both fit in 23 bits.
    localparam int unsigned USAGE_BITS = 23;
    localparam logic [USAGE_BITS-1:0] PERCENT_SCALE = 23'd100;

    typedef struct packed {
        logic nonempty;
        logic full;
    } queue_status_t;

endpackage
`default_nettype wire

// ===== src/two_queue_feedback_lottery_scheduler_unit.sv =====
// Top level of the two-queue feedback lottery scheduler: APB registers,
// request sequencing and result register. Depends on tqfl_pkg, tqfl_queue.
`default_nettype none
// Each request passes through a push state and a pop state: in the push
// state the returning process is classed and pushed into the fast or slow
// queue, in the pop state a pid is drawn from one queue and written to the
// result register. Each queue is a row of shifting cells that moves by at
// most one slot a cycle, so the push and the pop take separate states; a new
// request is taken in the pop state of the previous one as long as the result
// register is free or being emptied. There is no clearing pass after reset.
// Registers sit at byte addresses 0 (quantum), 4 (threshold percent) and 8 (fast share percent).
module two_queue_feedback_lottery_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // APB configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    // Request channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_has_current,
    input  wire logic [PID_BITS-1:0] s_pid,
    input  wire logic [15:0]         s_used_time,
    input  wire logic [1:0]          s_exit_state,
    input  wire logic [6:0]          s_random_draw,
    // Result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_selected_valid,
    output logic      [PID_BITS-1:0] m_selected_pid,
    output logic                     m_selected_queue,
    output logic      [2:0]          m_routed_dest,
    output logic                     m_routed_class,
    output logic      [1:0]          m_error_code
);

    localparam int UB = tqfl_pkg::USAGE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    // Configuration registers
    logic [15:0]   quantum_reg;
    logic [6:0]    threshold_reg;
    logic [6:0]    share_reg;
    logic [UB-1:0] limit_reg;
    logic          cfg_write;

    // Sequencing
    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;
    logic       out_free;

    // Captured request
    logic                has_current_reg;
    logic [PID_BITS-1:0] pid_reg;
    logic [UB-1:0]       usage_reg;
    logic [1:0]          exit_reg;
    logic [6:0]          draw_reg;

    // Routing outcome of the push cycle
    logic [2:0] dest_reg;
    logic       class_reg;
    logic [1:0] err_reg;
    logic [2:0] dest_next;
    logic       class_next;
    logic [1:0] err_next;
    logic       push_fast;
    logic       push_slow;
    logic       cls;

    // Queues
    logic                    pop_fast;
    logic                    pop_slow;
    logic [PID_BITS-1:0]     fast_head;
    logic [PID_BITS-1:0]     slow_head;
    tqfl_pkg::queue_status_t fast_status;
    tqfl_pkg::queue_status_t slow_status;
    logic                    take_fast;
    logic                    take_slow;

    // Result register
    logic                m_valid_reg;
    logic                sel_valid_reg;
    logic [PID_BITS-1:0] sel_pid_reg;
    logic                sel_queue_reg;
    logic [2:0]          dest_out_reg;
    logic                class_out_reg;
    logic [1:0]          err_out_reg;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg   <= tqfl_pkg::QUANTUM_RESET;
            threshold_reg <= tqfl_pkg::THRESHOLD_RESET;
            share_reg     <= tqfl_pkg::FAST_SHARE_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                tqfl_pkg::REG_QUANTUM:    quantum_reg   <= pwdata[15:0];
                tqfl_pkg::REG_THRESHOLD:  threshold_reg <= pwdata[6:0];
                tqfl_pkg::REG_FAST_SHARE: share_reg     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tqfl_pkg::REG_QUANTUM:    prdata = {16'd0, quantum_reg};
            tqfl_pkg::REG_THRESHOLD:  prdata = {25'd0, threshold_reg};
            tqfl_pkg::REG_FAST_SHARE: prdata = {25'd0, share_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // The class limit is a registered copy that only moves on configuration
    // writes; the user must make these while idle, which is not enforced.
    always_ff @(posedge aclk) begin
        limit_reg <= UB'({16'd0, threshold_reg} * {7'd0, quantum_reg});
    end

    // ---------------------------------------------------------------
    // Sequencing
    // ---------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_POP) && out_free);
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: state_next = ST_POP;
            ST_POP: begin
                if (out_free) begin
                    state_next = accept ? ST_PUSH : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            has_current_reg <= s_has_current;
            pid_reg         <= s_pid;
            usage_reg       <= UB'({7'd0, s_used_time} * tqfl_pkg::PERCENT_SCALE);
            exit_reg        <= s_exit_state;
            draw_reg        <= s_random_draw;
        end
    end

    // ---------------------------------------------------------------
    // Push cycle: class the returning process and route it
    // ---------------------------------------------------------------
    assign cls = (usage_reg < limit_reg) ? tqfl_pkg::CLASS_FAST : tqfl_pkg::CLASS_SLOW;

    always_comb begin
        dest_next  = tqfl_pkg::DEST_NONE;
        class_next = tqfl_pkg::CLASS_FAST;
        err_next   = tqfl_pkg::ERR_OK;
        push_fast  = 1'b0;
        push_slow  = 1'b0;
        if (has_current_reg) begin
            class_next = cls;
            case (exit_reg)
                tqfl_pkg::EXIT_READY: begin
                    if (cls == tqfl_pkg::CLASS_FAST) begin
                        dest_next = tqfl_pkg::DEST_FAST;
                        push_fast = (state_reg == ST_PUSH);
                        if (fast_status.full) begin
                            err_next = tqfl_pkg::ERR_QUEUE_FULL;
                        end
                    end else begin
                        dest_next = tqfl_pkg::DEST_SLOW;
                        push_slow = (state_reg == ST_PUSH);
                        if (slow_status.full) begin
                            err_next = tqfl_pkg::ERR_QUEUE_FULL;
                        end
                    end
                end
                tqfl_pkg::EXIT_BLOCKED:  dest_next = tqfl_pkg::DEST_BLOCKED;
                tqfl_pkg::EXIT_FINISHED: dest_next = tqfl_pkg::DEST_FINISHED;
                default:                 err_next  = tqfl_pkg::ERR_BAD_EXIT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PUSH) begin
            dest_reg  <= dest_next;
            class_reg <= class_next;
            err_reg   <= err_next;
        end
    end

    // ---------------------------------------------------------------
    // Queues
    // ---------------------------------------------------------------
    tqfl_queue #(
        .DEPTH    (QUEUE_DEPTH),
        .PID_BITS (PID_BITS)
    ) u_fast_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_fast),
        .push_pid (pid_reg),
        .pop      (pop_fast),
        .head_pid (fast_head),
        .status   (fast_status)
    );

    tqfl_queue #(
        .DEPTH    (QUEUE_DEPTH),
        .PID_BITS (PID_BITS)
    ) u_slow_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_slow),
        .push_pid (pid_reg),
        .pop      (pop_slow),
        .head_pid (slow_head),
        .status   (slow_status)
    );

    // ---------------------------------------------------------------
    // Pop cycle: lottery between the queues
    // ---------------------------------------------------------------
    assign take_fast = fast_status.nonempty && (!slow_status.nonempty || (draw_reg < share_reg));
    assign take_slow = !take_fast && slow_status.nonempty;
    assign pop_fast  = (state_reg == ST_POP) && out_free && take_fast;
    assign pop_slow  = (state_reg == ST_POP) && out_free && take_slow;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_POP) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_POP) && out_free) begin
            sel_valid_reg <= take_fast || take_slow;
            if (take_fast) begin
                sel_pid_reg   <= fast_head;
                sel_queue_reg <= tqfl_pkg::QUEUE_FAST;
            end else if (take_slow) begin
                sel_pid_reg   <= slow_head;
                sel_queue_reg <= tqfl_pkg::QUEUE_SLOW;
            end else begin
                sel_pid_reg   <= '0;
                sel_queue_reg <= tqfl_pkg::QUEUE_FAST;
            end
            dest_out_reg  <= dest_reg;
            class_out_reg <= class_reg;
            err_out_reg   <= err_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_selected_valid = sel_valid_reg;
    assign m_selected_pid   = sel_pid_reg;
    assign m_selected_queue = sel_queue_reg;
    assign m_routed_dest    = dest_out_reg;
    assign m_routed_class   = class_out_reg;
    assign m_error_code     = err_out_reg;

endmodule
`default_nettype wire

// ===== src/tqfl_cell.sv =====
// One storage cell of a shifting queue: holds one pid and takes its
// neighbor's pid when the queue pops. No package dependency.
`default_nettype none
module tqfl_cell #(
    parameter int PID_BITS = 8
) (
    input  wire logic                aclk,
    input  wire logic                shift,
    input  wire logic                load,
    input  wire logic [PID_BITS-1:0] din_new,
    input  wire logic [PID_BITS-1:0] din_next,
    output logic      [PID_BITS-1:0] dout
);

    logic [PID_BITS-1:0] pid_reg;

    // Push and pop never happen in the same cycle, so the order is free.
    always_ff @(posedge aclk) begin
        if (shift) begin
            pid_reg <= din_next;
        end else if (load) begin
            pid_reg <= din_new;
        end
    end

    assign dout = pid_reg;

endmodule
`default_nettype wire

// ===== src/tqfl_queue.sv =====
// Shifting FIFO built from a row of tqfl_cell; the head is always cell 0.
// Depends on tqfl_pkg and tqfl_cell.
`default_nettype none
module tqfl_queue #(
    parameter int DEPTH    = 16,
    parameter int PID_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire logic [PID_BITS-1:0]   push_pid,
    input  wire logic                  pop,
    output logic      [PID_BITS-1:0]   head_pid,
    output tqfl_pkg::queue_status_t    status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                full;
    logic                do_push;
    logic                do_pop;
    logic [PID_BITS-1:0] cell_data [DEPTH];

    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    always_comb begin
        count_next = count_reg;
        if (do_push) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // The tail slot is the first empty cell, whose index equals the count.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [PID_BITS-1:0] next_data;
        if (i == DEPTH - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_mid
            assign next_data = cell_data[i+1];
        end
        tqfl_cell #(
            .PID_BITS (PID_BITS)
        ) u_cell (
            .aclk     (aclk),
            .shift    (do_pop),
            .load     (do_push && (count_reg == CW'(i))),
            .din_new  (push_pid),
            .din_next (next_data),
            .dout     (cell_data[i])
        );
    end

    assign head_pid        = cell_data[0];
    assign status.nonempty = (count_reg != '0);
    assign status.full     = full;

endmodule
`default_nettype wire

// ===== src/tqfl_checker.sv =====
// Port-level checks for the scheduler and their bind to the top level.
// Depends on tqfl_pkg and two_queue_feedback_lottery_scheduler_unit.
`default_nettype none
module tqfl_checker #(
    parameter int PID_BITS = 8
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic                m_selected_valid,
    input wire logic [PID_BITS-1:0] m_selected_pid,
    input wire logic                m_selected_queue,
    input wire logic [2:0]          m_routed_dest,
    input wire logic [1:0]          m_error_code
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_selected_pid)
            && $stable(m_routed_dest) && $stable(m_error_code)))
        else $error("stalled result changed");

    a_no_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_selected_valid) |->
            (m_selected_pid == '0 && m_selected_queue == tqfl_pkg::QUEUE_FAST))
        else $error("empty pick carries a pid or queue");

    a_bad_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code == tqfl_pkg::ERR_BAD_EXIT) |->
            (m_routed_dest == tqfl_pkg::DEST_NONE))
        else $error("invalid exit state was routed");

    a_full_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code == tqfl_pkg::ERR_QUEUE_FULL) |->
            (m_routed_dest == tqfl_pkg::DEST_FAST || m_routed_dest == tqfl_pkg::DEST_SLOW))
        else $error("queue full reported for a process not meant for a queue");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_error_code != tqfl_pkg::ERR_UNUSED))
        else $error("undefined error code");

endmodule

bind two_queue_feedback_lottery_scheduler_unit tqfl_checker #(
    .PID_BITS (PID_BITS)
) u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_selected_valid (m_selected_valid),
    .m_selected_pid   (m_selected_pid),
    .m_selected_queue (m_selected_queue),
    .m_routed_dest    (m_routed_dest),
    .m_error_code     (m_error_code)
);
`default_nettype wire
